// File: sv/ddalr_pkg.sv
// Shared control types and microprogram for the DDA line rasterizer.
package ddalr_pkg;

	// Microprogram step addresses
	localparam int STEP_BITS = 2;
	typedef logic [STEP_BITS-1:0] step_t;

	localparam step_t STEP_DISPATCH = 2'd0;
	localparam step_t STEP_SETUP    = 2'd1;
	localparam step_t STEP_DIVIDE   = 2'd2;
	localparam step_t STEP_SIGN     = 2'd3;

	// Input item kinds carried on the slave tuser
	localparam logic OP_START = 1'b0;
	localparam logic OP_NEXT  = 1'b1;

	// Jump conditions
	typedef enum logic [1:0] {
		COND_ALWAYS  = 2'd0,
		COND_START   = 2'd1,
		COND_NODIV   = 2'd2,
		COND_DIVLAST = 2'd3
	} cond_t;

	// One control word of the microprogram
	typedef struct packed {
		logic  accept;    // take input beats in this step
		logic  load_div;  // load the divider with magnitude and dx
		logic  div_step;  // run one quotient bit
		logic  fix_sign;  // write the signed slope from the quotient
		cond_t cond;      // jump condition
		logic  adv;       // on no jump: 1 = advance, 0 = hold
		step_t target;    // jump target
	} ctrl_t;

	// Status flags fed back from the datapath to the sequencer
	typedef struct packed {
		logic start_fire;  // a start beat is accepted this cycle
		logic no_div;      // latched line needs no division
		logic div_last;    // divider runs its final bit this cycle
	} stat_t;

	// Microprogram read-only table
	function automatic ctrl_t ucode_rom(input step_t addr);
		ctrl_t w;
		w = '{accept: 1'b0, load_div: 1'b0, div_step: 1'b0, fix_sign: 1'b0,
			cond: COND_ALWAYS, adv: 1'b0, target: STEP_DISPATCH};
		case (addr)
			STEP_DISPATCH: begin
				w.accept = 1'b1;
				w.cond   = COND_START;
				w.target = STEP_SETUP;
				w.adv    = 1'b0;
			end
			STEP_SETUP: begin
				w.load_div = 1'b1;
				w.cond     = COND_NODIV;
				w.target   = STEP_DISPATCH;
				w.adv      = 1'b1;
			end
			STEP_DIVIDE: begin
				w.div_step = 1'b1;
				w.cond     = COND_DIVLAST;
				w.target   = STEP_SIGN;
				w.adv      = 1'b0;
			end
			STEP_SIGN: begin
				w.fix_sign = 1'b1;
				w.cond     = COND_ALWAYS;
				w.target   = STEP_DISPATCH;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_DISPATCH;
			end
		endcase
		return w;
	endfunction

endpackage

// File: sv/ddalr_divider.sv
// Restoring divider, one quotient bit per cycle while step is high, for the line slope.
module ddalr_divider #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic                           step,
	input  logic [COORD_BITS-1:0]          mag,
	input  logic [COORD_BITS-1:0]          divisor,
	output logic [COORD_BITS+FRAC_BITS-1:0] quotient,
	output logic                           last
);

	localparam int QW = COORD_BITS + FRAC_BITS;
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0]         quo_q;
	logic [COORD_BITS-1:0] rem_q;
	logic [CW-1:0]         cnt_q;
	logic [COORD_BITS:0]   trial;
	logic                  fits;

	// Shift in the next dividend bit and test against the divisor
	assign trial = {rem_q, quo_q[QW-1]};
	assign fits  = trial >= {1'b0, divisor};

	// Count the remaining quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CW'(QW);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Advance remainder and quotient
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			quo_q <= {mag, {FRAC_BITS{1'b0}}};
		end else if (step) begin
			if (fits) begin
				rem_q <= COORD_BITS'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[COORD_BITS-1:0];
			end
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign last     = (cnt_q == CW'(1));

endmodule

// File: sv/ddalr_sequencer.sv
// Step counter and microprogram table that drive the rasterizer datapath.
module ddalr_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  ddalr_pkg::stat_t    stat,
	output ddalr_pkg::ctrl_t    ctrl
);

	ddalr_pkg::step_t step_q;
	ddalr_pkg::step_t step_nxt;
	logic             hit;

	// Fetch the control word of the current step
	assign ctrl = ddalr_pkg::ucode_rom(step_q);

	// Evaluate the jump condition
	always_comb begin
		case (ctrl.cond)
			ddalr_pkg::COND_ALWAYS:  hit = 1'b1;
			ddalr_pkg::COND_START:   hit = stat.start_fire;
			ddalr_pkg::COND_NODIV:   hit = stat.no_div;
			ddalr_pkg::COND_DIVLAST: hit = stat.div_last;
			default:                 hit = 1'b1;
		endcase
	end

	// Jump, advance or hold
	always_comb begin
		if (hit) begin
			step_nxt = ctrl.target;
		end else if (ctrl.adv) begin
			step_nxt = step_q + 1'b1;
		end else begin
			step_nxt = step_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ddalr_pkg::STEP_DISPATCH;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

// File: sv/dda_line_rasterizer.sv
// Top level of the DDA line rasterizer: datapath, output register and control.
//
//  channel   | dir | beat contents
//  ----------+-----+-------------------------------------------------------
//  s_axis    | in  | tuser = op; tdata = x_start, y_start, x_end, y_end
//  m_axis    | out | tdata = pixel_x, pixel_y; tuser = pixel_valid;
//            |     | tlast = last_pixel
//
// Next beats give one pixel per cycle while the output is taken.
// A start beat runs the setup step and, unless x_end <= x_start, the divide and
// sign steps, the divider forming one slope bit per cycle; no beat is taken then.
// A start beat produces no output beat; a next beat always produces one.
// Reset clears the step counter, the line-active flag and the output valid flag.
// A stalled output holds its beat; the input is refused until it frees.
module dda_line_rasterizer #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// tdata: x_start, y_start, x_end, y_end (from bit 0 up)
	input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	// tuser: op
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// tdata: pixel_x, pixel_y (from bit 0 up), zero padded
	output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
	// tuser: pixel_valid
	output logic                   m_axis_tuser,
	output logic                   m_axis_tlast
);

	localparam int C  = COORD_BITS;
	localparam int QW = COORD_BITS + FRAC_BITS;
	localparam int SW = QW + 1;
	localparam int AW = QW + 2;
	localparam int OW = ((2*COORD_BITS+7)/8)*8;
	localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

	ddalr_pkg::ctrl_t ctrl;
	ddalr_pkg::stat_t stat;

	logic [C-1:0] xs, ys, xe, ye;
	logic         in_fire, start_fire, next_fire;

	logic [C-1:0]            cur_x_q, fin_x_q, dx_q, mag_q;
	logic signed [AW-1:0]    acc_q;
	logic signed [SW-1:0]    slope_q;
	logic                    active_q, neg_q, nodiv_q;

	logic [QW-1:0]           quotient;
	logic                    div_last;

	logic signed [AW-1:0]    acc_rnd;
	logic [C:0]              y_wide;
	logic [C-1:0]            y_pix;
	logic                    at_end;

	logic                    out_valid_q, out_pv_q, out_last_q;
	logic [C-1:0]            out_x_q, out_y_q;

	assign xs = s_axis_tdata[C-1:0];
	assign ys = s_axis_tdata[2*C-1:C];
	assign xe = s_axis_tdata[3*C-1:2*C];
	assign ye = s_axis_tdata[4*C-1:3*C];

	// Accept a beat only in the dispatch step with room in the output register
	assign s_axis_tready = ctrl.accept && (!out_valid_q || m_axis_tready);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign start_fire    = in_fire && (s_axis_tuser == ddalr_pkg::OP_START);
	assign next_fire     = in_fire && (s_axis_tuser == ddalr_pkg::OP_NEXT);

	assign stat = '{start_fire: start_fire, no_div: nodiv_q, div_last: div_last};

	ddalr_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	ddalr_divider #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (ctrl.load_div),
		.step     (ctrl.div_step),
		.mag      (mag_q),
		.divisor  (dx_q),
		.quotient (quotient),
		.last     (div_last)
	);

	// Round the accumulator half up and clamp to the coordinate range
	assign acc_rnd = acc_q + HALF;
	assign y_wide  = acc_rnd[AW-2:FRAC_BITS];
	always_comb begin
		if (acc_q[AW-1]) begin
			y_pix = '0;
		end else if (y_wide[C]) begin
			y_pix = '1;
		end else begin
			y_pix = y_wide[C-1:0];
		end
	end

	assign at_end = cur_x_q >= fin_x_q;

	// Track whether a line is in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (start_fire) begin
			active_q <= (xe >= xs);
		end else if (next_fire && active_q && at_end) begin
			active_q <= 1'b0;
		end
	end

	// Latch endpoints on start, write the slope in the sign step, step x and y on each emitted pixel but the last
	always_ff @(posedge clk) begin
		if (start_fire) begin
			cur_x_q <= xs;
			fin_x_q <= xe;
			acc_q   <= {2'b00, ys, {FRAC_BITS{1'b0}}};
			slope_q <= '0;
			dx_q    <= C'(xe - xs);
			neg_q   <= ye < ys;
			mag_q   <= (ye < ys) ? C'(ys - ye) : C'(ye - ys);
			nodiv_q <= (xe <= xs);
		end else if (ctrl.fix_sign) begin
			slope_q <= neg_q ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
		end else if (next_fire && active_q && !at_end) begin
			cur_x_q <= C'(cur_x_q + 1'b1);
			acc_q   <= acc_q + AW'(slope_q);
		end
	end

	// Output register: load on a next beat, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (next_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (next_fire) begin
			out_x_q    <= active_q ? cur_x_q : '0;
			out_y_q    <= active_q ? y_pix : '0;
			out_pv_q   <= active_q;
			out_last_q <= active_q && at_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OW'({out_y_q, out_x_q});
	assign m_axis_tuser  = out_pv_q;
	assign m_axis_tlast  = out_last_q;

	// A new output beat only follows an accepted next beat
	a_out_from_next: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(next_fire))
		else $error("output beat without an accepted next beat");

	// A beat flagged last is always a real pixel
	a_last_is_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
		else $error("last flag on an idle beat");

	// Emitting the final pixel ends the line
	a_line_ends: assert property (@(posedge clk) disable iff (!arst_n)
		next_fire && active_q && at_end |=> !active_q)
		else $error("line still active after its final pixel");

	// Input is never taken while the slope is being formed
	a_no_take_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.div_step || ctrl.fix_sign || ctrl.load_div |-> !s_axis_tready)
		else $error("input taken during slope division");

endmodule
